FILE: design/kbr_pkg.sv
// Shared types and constants for the keyboard rollover report block.
`default_nettype none
package kbr_pkg;

  // Depth of the held-key list.
  localparam int MaxKeys = 6;
  // Slots shown in one report.
  localparam int ReportSlots = 6;
  // The report count field saturates at this value.
  localparam int CountCap = 7;
  localparam int CodeW = 8;
  localparam int CountOutW = 3;
  localparam int KeyIdxW = (MaxKeys > 1) ? $clog2(MaxKeys) : 1;
  localparam int CountW = $clog2(MaxKeys + 1);

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_SCAN,
    SEQ_SHIFT,
    SEQ_REPORT
  } seq_state_e;

  typedef enum logic [1:0] {
    KOP_NONE,
    KOP_WRITE,
    KOP_PUSH,
    KOP_POP
  } key_op_e;

  // One write into the key list, issued by the sequencer.
  typedef struct packed {
    key_op_e              op;
    logic [KeyIdxW-1:0]   idx;
    logic [CodeW-1:0]     data;
  } key_cmd_t;

endpackage
`default_nettype wire

FILE: design/kbr_keys.sv
// Held-key list storage with one indexed read port, one write port, the count and the report slots.
`default_nettype none
module kbr_keys
  import kbr_pkg::*;
(
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire key_cmd_t                          cmd_i,
  input  wire logic [CountW-1:0]                 rd_idx_i,
  output logic      [CodeW-1:0]                  rd_key_o,
  output logic      [CountW-1:0]                 total_o,
  output logic      [ReportSlots-1:0][CodeW-1:0] slots_o
);

  logic [CodeW-1:0]  keys_q [MaxKeys];
  logic [CountW-1:0] total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MaxKeys; i++) begin
        keys_q[i] <= '0;
      end
      total_q <= '0;
    end else begin
      unique case (cmd_i.op)
        KOP_NONE: ;
        KOP_WRITE: begin
          keys_q[cmd_i.idx] <= cmd_i.data;
        end
        KOP_PUSH: begin
          keys_q[cmd_i.idx] <= cmd_i.data;
          total_q           <= total_q + CountW'(1);
        end
        KOP_POP: begin
          keys_q[cmd_i.idx] <= cmd_i.data;
          total_q           <= total_q - CountW'(1);
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    rd_key_o = '0;
    if (rd_idx_i < CountW'(MaxKeys)) begin
      rd_key_o = keys_q[rd_idx_i[KeyIdxW-1:0]];
    end
  end

  assign total_o = total_q;

  for (genvar s = 0; s < ReportSlots; s++) begin : g_slot
    if (s < MaxKeys) begin : g_held
      assign slots_o[s] = (CountW'(s) < total_q) ? keys_q[s] : '0;
    end else begin : g_empty
      assign slots_o[s] = '0;
    end
  end

endmodule
`default_nettype wire

FILE: design/kbr_seq.sv
// Sequencer that scans the key list with one shared comparator and edits it.
`default_nettype none
module kbr_seq
  import kbr_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 operation_i,
  input  wire logic                 is_repeat_i,
  input  wire logic [CodeW-1:0]     usage_code_i,
  input  wire logic                 out_free_i,
  output logic                      rpt_load_o,
  input  wire logic [CodeW-1:0]     rd_key_i,
  input  wire logic [CountW-1:0]    total_i,
  output logic      [CountW-1:0]    rd_idx_o,
  output key_cmd_t                  cmd_o
);

  seq_state_e        state_q, state_d;
  logic [CountW-1:0] idx_q, idx_d;
  logic              release_q, release_d;
  logic [CodeW-1:0]  code_q, code_d;
  logic [CountW-1:0] idx_nx;
  logic              hit;

  assign idx_nx = idx_q + CountW'(1);
  assign hit    = (rd_key_i == code_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SEQ_IDLE;
      idx_q     <= '0;
      release_q <= 1'b0;
      code_q    <= '0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      release_q <= release_d;
      code_q    <= code_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    release_d  = release_q;
    code_d     = code_q;
    in_ready_o = 1'b0;
    rpt_load_o = 1'b0;
    rd_idx_o   = idx_q;
    cmd_o      = '{op: KOP_NONE, idx: idx_q[KeyIdxW-1:0], data: '0};

    unique case (state_q)
      SEQ_IDLE: begin
        in_ready_o = 1'b1;
        // Auto-repeat presses and unmapped keys leave no trace.
        if (in_valid_i && !(!operation_i && is_repeat_i) && (usage_code_i != '0)) begin
          release_d = operation_i;
          code_d    = usage_code_i;
          idx_d     = '0;
          state_d   = SEQ_SCAN;
        end
      end
      SEQ_SCAN: begin
        if (idx_q == total_i) begin
          if (!release_q && (total_i < CountW'(MaxKeys))) begin
            cmd_o = '{op: KOP_PUSH, idx: total_i[KeyIdxW-1:0], data: code_q};
          end
          state_d = SEQ_REPORT;
        end else if (hit) begin
          state_d = release_q ? SEQ_SHIFT : SEQ_REPORT;
        end else begin
          idx_d = idx_nx;
        end
      end
      SEQ_SHIFT: begin
        // Pull the following entry down one place; the last place is cleared.
        rd_idx_o = idx_nx;
        if (idx_nx < total_i) begin
          cmd_o = '{op: KOP_WRITE, idx: idx_q[KeyIdxW-1:0], data: rd_key_i};
          idx_d = idx_nx;
        end else begin
          cmd_o   = '{op: KOP_POP, idx: idx_q[KeyIdxW-1:0], data: '0};
          state_d = SEQ_REPORT;
        end
      end
      SEQ_REPORT: begin
        if (out_free_i) begin
          rpt_load_o = 1'b1;
          state_d    = SEQ_IDLE;
        end
      end
      default: begin
        state_d = SEQ_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: design/keyboard_rollover_report.sv
// Keyboard rollover report: top level with input capture and report register.
// Each key event beat updates an ordered list of up to six held HID usage
// codes and yields one boot-keyboard report (modifiers, six slots, count).
// Auto-repeat presses and usage code zero are dropped without a report. For
// any other event, one comparator walks the list one entry per cycle until
// it finds the code or passes the last entry; a press of an absent code
// appends it while the list has room. On a release of a held key, the
// entries behind it move down one entry per cycle and the last place is
// cleared. The report is then loaded once the output is free. The block
// takes a new event while the previous report still waits on the output.
`default_nettype none
module keyboard_rollover_report
  import kbr_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic                 operation_i,
  input  wire logic                 is_repeat_i,
  input  wire logic [CodeW-1:0]     usage_code_i,
  input  wire logic [CodeW-1:0]     modifier_bits_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic      [CodeW-1:0]     report_modifiers_o,
  output logic      [CodeW-1:0]     slot_0_o,
  output logic      [CodeW-1:0]     slot_1_o,
  output logic      [CodeW-1:0]     slot_2_o,
  output logic      [CodeW-1:0]     slot_3_o,
  output logic      [CodeW-1:0]     slot_4_o,
  output logic      [CodeW-1:0]     slot_5_o,
  output logic      [CountOutW-1:0] held_count_o
);

  logic                              rpt_load;
  logic                              out_free;
  logic [CodeW-1:0]                  rd_key;
  logic [CountW-1:0]                 total;
  logic [CountW-1:0]                 rd_idx;
  key_cmd_t                          cmd;
  logic [ReportSlots-1:0][CodeW-1:0] slots;

  logic                              out_valid_q;
  logic [CodeW-1:0]                  mods_q;
  logic [CodeW-1:0]                  rpt_mods_q;
  logic [ReportSlots-1:0][CodeW-1:0] rpt_slots_q;
  logic [CountOutW-1:0]              rpt_count_q;
  logic [CountOutW-1:0]              count_sat;

  assign out_free  = !out_valid_q || out_ready_i;
  assign count_sat = (32'(total) > 32'(CountCap)) ? CountOutW'(CountCap)
                                                  : CountOutW'(total);

  kbr_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .is_repeat_i (is_repeat_i),
    .usage_code_i(usage_code_i),
    .out_free_i  (out_free),
    .rpt_load_o  (rpt_load),
    .rd_key_i    (rd_key),
    .total_i     (total),
    .rd_idx_o    (rd_idx),
    .cmd_o       (cmd)
  );

  kbr_keys u_keys (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .rd_idx_i(rd_idx),
    .rd_key_o(rd_key),
    .total_o (total),
    .slots_o (slots)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rpt_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mods_q <= modifier_bits_i;
    end
    if (rpt_load) begin
      rpt_mods_q  <= mods_q;
      rpt_slots_q <= slots;
      rpt_count_q <= count_sat;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign report_modifiers_o = rpt_mods_q;
  assign slot_0_o           = rpt_slots_q[0];
  assign slot_1_o           = rpt_slots_q[1];
  assign slot_2_o           = rpt_slots_q[2];
  assign slot_3_o           = rpt_slots_q[3];
  assign slot_4_o           = rpt_slots_q[4];
  assign slot_5_o           = rpt_slots_q[5];
  assign held_count_o       = rpt_count_q;

endmodule
`default_nettype wire

FILE: verif/keyboard_rollover_report_tb.sv
// Self-checking testbench for the keyboard rollover report block.
`timescale 1ns / 1ps
module keyboard_rollover_report_tb;
  import kbr_pkg::*;

  localparam logic KeyPress = 1'b0;
  localparam logic KeyRelease = 1'b1;
  localparam logic [CodeW-1:0] NoKey = '0;
  localparam int RandomReports = 965;
  localparam int PoolSize = 10;
  localparam int CycleLimit = 1_000_000;
  localparam int DrainLimit = 2000;
  // Worst event latency plus some margin, to catch a stray late report.
  localparam int SettleCycles = MaxKeys + 3 + 10;
  localparam int MaxPrinted = 30;

  typedef struct packed {
    logic [CodeW-1:0]                  mods;
    logic [ReportSlots-1:0][CodeW-1:0] slots;
    logic [CountOutW-1:0]              count;
  } hid_report_t;

  // Tracks the held-key list and the reports it must produce, in order.
  class report_scoreboard;
    logic [CodeW-1:0] held_codes [MaxKeys] = '{default: '0};
    int               held_len = 0;
    hid_report_t      expected_q [$];
    int errors = 0;
    int checked = 0;
    int events = 0;
    int ignored = 0;
    int drops = 0;
    int fills = 0;

    task report_mismatch(string msg);
      errors++;
      if (errors <= MaxPrinted) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function int find_code(logic [CodeW-1:0] code);
      for (int i = 0; i < held_len; i++) begin
        if (held_codes[i] == code) return i;
      end
      return -1;
    endfunction

    function void note_event(logic release_op, logic repeat_flag,
                             logic [CodeW-1:0] code, logic [CodeW-1:0] mods);
      int          pos;
      hid_report_t rpt;
      events++;
      if ((release_op == KeyPress && repeat_flag) || code == NoKey) begin
        ignored++;
        return;
      end
      pos = find_code(code);
      if (release_op == KeyRelease) begin
        if (pos >= 0) begin
          for (int j = pos; j < held_len - 1; j++) held_codes[j] = held_codes[j + 1];
          held_len--;
          held_codes[held_len] = NoKey;
        end
      end else if (pos < 0) begin
        if (held_len < MaxKeys) begin
          held_codes[held_len] = code;
          held_len++;
          if (held_len == MaxKeys) fills++;
        end else begin
          drops++;
        end
      end
      rpt.mods = mods;
      for (int i = 0; i < ReportSlots; i++) begin
        rpt.slots[i] = (i < held_len && i < MaxKeys) ? held_codes[i] : NoKey;
      end
      rpt.count = CountOutW'((held_len > CountCap) ? CountCap : held_len);
      expected_q.push_back(rpt);
    endfunction

    task check_report(hid_report_t got);
      hid_report_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("report with none expected: mods %h slots %h count %0d",
                                  got.mods, got.slots, got.count));
        return;
      end
      want = expected_q.pop_front();
      if (got.mods !== want.mods)
        report_mismatch($sformatf("report %0d modifiers %h, expected %h",
                                  checked, got.mods, want.mods));
      for (int i = 0; i < ReportSlots; i++) begin
        if (got.slots[i] !== want.slots[i])
          report_mismatch($sformatf("report %0d slot %0d is %h, expected %h",
                                    checked, i, got.slots[i], want.slots[i]));
      end
      if (got.count !== want.count)
        report_mismatch($sformatf("report %0d count %0d, expected %0d",
                                  checked, got.count, want.count));
      checked++;
    endtask
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic             operation_i;
  logic             is_repeat_i;
  logic [CodeW-1:0] usage_code_i;
  logic [CodeW-1:0] modifier_bits_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic [CodeW-1:0] report_modifiers_o;
  logic [CodeW-1:0] slot_0_o, slot_1_o, slot_2_o, slot_3_o, slot_4_o, slot_5_o;
  logic [CountOutW-1:0] held_count_o;

  report_scoreboard sb = new;
  // While set, neither side inserts gaps.
  logic quiet = 1'b0;
  int   cycle_count = 0;

  keyboard_rollover_report dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .operation_i        (operation_i),
    .is_repeat_i        (is_repeat_i),
    .usage_code_i       (usage_code_i),
    .modifier_bits_i    (modifier_bits_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .report_modifiers_o (report_modifiers_o),
    .slot_0_o           (slot_0_o),
    .slot_1_o           (slot_1_o),
    .slot_2_o           (slot_2_o),
    .slot_3_o           (slot_3_o),
    .slot_4_o           (slot_4_o),
    .slot_5_o           (slot_5_o),
    .held_count_o       (held_count_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("FAIL keyboard_rollover_report");
    $finish;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int random_gap();
    int roll;
    if (quiet) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Called at a rising edge; returns at the edge where the beat is taken.
  task automatic send_event(logic op, logic rep, logic [CodeW-1:0] code,
                            logic [CodeW-1:0] mods);
    int gap;
    gap = random_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    operation_i     <= op;
    is_repeat_i     <= rep;
    usage_code_i    <= code;
    modifier_bits_i <= mods;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_event(op, rep, code, mods);
  endtask

  initial begin : report_sink
    hid_report_t got;
    int          stall;
    stall = 0;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got.mods  = report_modifiers_o;
        got.slots = {slot_5_o, slot_4_o, slot_3_o, slot_2_o, slot_1_o, slot_0_o};
        got.count = held_count_o;
        sb.check_report(got);
      end
      if (stall > 0) begin
        stall--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        stall = random_gap();
      end
    end
  end

  initial begin : stimulus
    logic [CodeW-1:0] pool [PoolSize];
    logic [CodeW-1:0] code, mods;
    logic             op, rep;
    int               reports_sent, roll, guard;
    reports_sent = 0;
    guard = 0;
    rst_ni          <= 1'b0;
    in_valid_i      <= 1'b0;
    operation_i     <= KeyPress;
    is_repeat_i     <= 1'b0;
    usage_code_i    <= NoKey;
    modifier_bits_i <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_event(KeyPress,   1'b0, 8'h04, 8'h00);
    // Auto-repeat press and the unmapped keys give nothing.
    send_event(KeyPress,   1'b1, 8'h04, 8'hFF);
    send_event(KeyPress,   1'b0, NoKey, 8'h00);
    send_event(KeyRelease, 1'b1, NoKey, 8'h00);
    send_event(KeyRelease, 1'b0, 8'h10, 8'h01);
    send_event(KeyPress,   1'b0, 8'h05, 8'hFF);
    send_event(KeyPress,   1'b0, 8'h04, 8'h00);
    send_event(KeyPress,   1'b0, 8'h80, 8'h80);
    send_event(KeyPress,   1'b0, 8'h7F, 8'h7F);
    send_event(KeyPress,   1'b0, 8'hFF, 8'h00);
    send_event(KeyPress,   1'b0, 8'h01, 8'hFF);
    // List is full here, so this key is dropped.
    send_event(KeyPress,   1'b0, 8'h0A, 8'h00);
    // A repeat flag on a release is ignored and the gap closes.
    send_event(KeyRelease, 1'b1, 8'h80, 8'h00);
    send_event(KeyRelease, 1'b0, 8'h33, 8'h00);
    send_event(KeyPress,   1'b0, 8'h0A, 8'h00);
    send_event(KeyRelease, 1'b0, 8'h04, 8'h00);
    send_event(KeyRelease, 1'b0, 8'h0A, 8'h00);
    send_event(KeyPress,   1'b0, 8'hAA, 8'h55);
    send_event(KeyRelease, 1'b0, 8'h05, 8'hAA);
    send_event(KeyRelease, 1'b0, 8'h7F, 8'h00);
    send_event(KeyRelease, 1'b0, 8'hFF, 8'hFF);
    send_event(KeyRelease, 1'b0, 8'h01, 8'h00);
    send_event(KeyRelease, 1'b0, 8'hAA, 8'h00);

    foreach (pool[i]) pool[i] = CodeW'($urandom_range(1, 255));
    while (reports_sent < RandomReports) begin
      if ($urandom_range(0, 149) == 0) quiet = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 199) == 0)
        pool[$urandom_range(0, PoolSize - 1)] = CodeW'($urandom_range(1, 255));
      roll = $urandom_range(0, 99);
      mods = CodeW'($urandom);
      rep  = 1'b0;
      if (roll < 6) begin
        // Noise: auto-repeat presses and unmapped keys.
        if ($urandom_range(0, 1) == 1) begin
          op   = KeyPress;
          rep  = 1'b1;
          code = CodeW'($urandom_range(0, 255));
        end else begin
          op   = logic'($urandom_range(0, 1));
          rep  = logic'($urandom_range(0, 1));
          code = NoKey;
        end
      end else if (roll < 10) begin
        op   = KeyRelease;
        rep  = logic'($urandom_range(0, 1));
        code = CodeW'($urandom_range(1, 255));
      end else if (roll < 52 && sb.held_len > 0) begin
        op   = KeyRelease;
        rep  = ($urandom_range(0, 3) == 0);
        code = sb.held_codes[$urandom_range(0, sb.held_len - 1)];
      end else begin
        op   = KeyPress;
        code = ($urandom_range(0, 4) == 0) ? CodeW'($urandom_range(1, 255))
                                           : pool[$urandom_range(0, PoolSize - 1)];
      end
      if (!(op == KeyPress && rep) && code != NoKey) reports_sent++;
      send_event(op, rep, code, mods);
    end
    in_valid_i <= 1'b0;
    quiet = 1'b0;

    while (sb.expected_q.size() != 0 && guard < DrainLimit) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.expected_q.size() != 0)
      sb.report_mismatch($sformatf("%0d reports never arrived", sb.expected_q.size()));

    $display("Sent %0d key events (%0d ignored); checked %0d reports.",
             sb.events, sb.ignored, sb.checked);
    $display("The list filled %0d times and %0d presses were dropped while full.",
             sb.fills, sb.drops);
    if (sb.errors == 0) begin
      $display("PASS keyboard_rollover_report");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("FAIL keyboard_rollover_report");
    end
    $finish;
  end

endmodule
